// ===== rtl/trm_pkg.sv =====
// shared types and constants of the thermal runaway monitor
package trm_pkg;

    localparam int POWER_W = 7;
    localparam int TEMP_W  = 11;
    localparam int CNT_W   = 8;
    localparam int TIME_W  = 16;
    localparam int MS_W    = 32;
    localparam int PWM_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int LVL_W   = 3;

    typedef logic [LVL_W-1:0] t_level;

    localparam t_level LVL_NONE  = 3'd0;
    localparam t_level LVL_ONE   = 3'd1;
    localparam t_level LVL_TWO   = 3'd2;
    localparam t_level LVL_THREE = 3'd3;
    localparam t_level LVL_FOUR  = 3'd4;
    localparam t_level LVL_ABS   = 3'd5;

    typedef logic [IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_STEP_DEGREES   = 3'd0;
    localparam t_cfg_index CFG_ABSOLUTE_LIMIT = 3'd1;
    localparam t_cfg_index CFG_TIME_ONE       = 3'd2;
    localparam t_cfg_index CFG_TIME_TWO       = 3'd3;
    localparam t_cfg_index CFG_TIME_THREE     = 3'd4;
    localparam t_cfg_index CFG_TIME_FOUR      = 3'd5;
    localparam t_cfg_index CFG_TIME_ABS       = 3'd6;

    localparam logic [7:0]        RST_STEP_DEGREES   = 8'd25;
    localparam logic [9:0]        RST_ABSOLUTE_LIMIT = 10'd500;
    localparam logic [TIME_W-1:0] RST_TIME_ONE       = 16'd20000;
    localparam logic [TIME_W-1:0] RST_TIME_TWO       = 16'd10000;
    localparam logic [TIME_W-1:0] RST_TIME_THREE     = 16'd5000;
    localparam logic [TIME_W-1:0] RST_TIME_FOUR      = 16'd2000;
    localparam logic [TIME_W-1:0] RST_TIME_ABS       = 16'd2000;

    typedef struct packed {
        logic [7:0] step_degrees;
        logic [9:0] absolute_limit;
    } t_grade_cfg;

    typedef struct packed {
        t_level               level;
        t_level               fault;
        logic                 tripped;
        logic                 pwm_fault;
        logic [POWER_W-1:0]   avg;
    } t_result;

endpackage

// ===== rtl/trm_hist_cell.sv =====
// one cell of the power history shift chain
module trm_hist_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic                        i_clear,
    input  logic [trm_pkg::POWER_W-1:0] i_data,
    output logic [trm_pkg::POWER_W-1:0] o_data
);

    logic [trm_pkg::POWER_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else if (i_shift) begin
            r_value <= i_data;
        end else if (i_clear) begin
            r_value <= '0;
        end
    end

    assign o_data = r_value;

endmodule

// ===== rtl/trm_grade.sv =====
// overrun level grading of tip against target and absolute limit
module trm_grade (
    input  logic signed [trm_pkg::TEMP_W-1:0] i_tip,
    input  logic signed [trm_pkg::TEMP_W-1:0] i_target,
    input  trm_pkg::t_grade_cfg               i_cfg,
    output trm_pkg::t_level                   o_level
);

    localparam int THR_W = trm_pkg::TEMP_W + 2;

    logic signed [THR_W-1:0] w_tip;
    logic signed [THR_W-1:0] w_target;
    logic signed [THR_W-1:0] w_abs;
    logic [4:1]              w_above;

    assign w_tip    = THR_W'(i_tip);
    assign w_target = THR_W'(i_target);
    assign w_abs    = $signed({3'b000, i_cfg.absolute_limit});

    // tip above target plus c steps, c = 1..4
    always_comb begin
        for (int c = 1; c <= 4; c++) begin
            w_above[c] = w_tip > (w_target
                + $signed({3'b000, 10'(i_cfg.step_degrees * 10'(c))}));
        end
    end

    always_comb begin
        priority if (w_tip > w_abs) begin
            o_level = trm_pkg::LVL_ABS;
        end else if (w_above[4]) begin
            o_level = trm_pkg::LVL_FOUR;
        end else if (w_above[3]) begin
            o_level = trm_pkg::LVL_THREE;
        end else if (w_above[2]) begin
            o_level = trm_pkg::LVL_TWO;
        end else if (w_above[1]) begin
            o_level = trm_pkg::LVL_ONE;
        end else begin
            o_level = trm_pkg::LVL_NONE;
        end
    end

endmodule

// ===== rtl/thermal_runaway_monitor_unit.sv =====
// thermal runaway monitor top level: history chain, grading, trip timer, output buffer
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall      | now_ms power tip target flags pwm x3
//  out     | output    | o_out_valid / i_out_stall    | level fault tripped pwm_fault avg
//  cfg     | input     | i_cfg_we, no handshake back  | i_cfg_index, i_cfg_data
//
// one check per cycle while the input is not stalled; its result is registered in
// the output register, or in the skid entry while the output register is held. all
// state of a check (history chain, running sum, timer) updates as its beat is taken. an
// output register plus one skid entry part the sides; the input stalls only while the
// skid entry is full. synchronous reset clears history, counters, latch and valid bits.
module thermal_runaway_monitor_unit #(
    parameter int HISTORY_DEPTH = 8,
    parameter int RESET_CHECKS  = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [trm_pkg::MS_W-1:0]          i_now_ms,
    input  logic [trm_pkg::POWER_W-1:0]       i_power_pct,
    input  logic signed [trm_pkg::TEMP_W-1:0] i_tip_temp,
    input  logic signed [trm_pkg::TEMP_W-1:0] i_target_temp,
    input  logic                              i_bypass,
    input  logic                              i_restart_history,
    input  logic [trm_pkg::PWM_W-1:0]         i_pwm_out,
    input  logic [trm_pkg::PWM_W-1:0]         i_pwm_period,
    input  logic [trm_pkg::PWM_W-1:0]         i_pwm_readback,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [trm_pkg::LVL_W-1:0]         o_overrun_level,
    output logic [trm_pkg::LVL_W-1:0]         o_fault_code,
    output logic                              o_tripped,
    output logic                              o_pwm_fault,
    output logic [trm_pkg::POWER_W-1:0]       o_average_power,
    input  logic                              i_cfg_we,
    input  logic [trm_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [trm_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int PW      = trm_pkg::POWER_W;
    localparam int SUM_W   = PW + $clog2(HISTORY_DEPTH);
    localparam int SHIFT   = SUM_W + $clog2(HISTORY_DEPTH);
    localparam int RECIP   = ((1 << SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int CW      = trm_pkg::CNT_W;

    // configuration registers
    logic [7:0]                r_step_degrees;
    logic [9:0]                r_absolute_limit;
    logic [trm_pkg::TIME_W-1:0] r_time_one;
    logic [trm_pkg::TIME_W-1:0] r_time_two;
    logic [trm_pkg::TIME_W-1:0] r_time_three;
    logic [trm_pkg::TIME_W-1:0] r_time_four;
    logic [trm_pkg::TIME_W-1:0] r_time_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_degrees   <= trm_pkg::RST_STEP_DEGREES;
            r_absolute_limit <= trm_pkg::RST_ABSOLUTE_LIMIT;
            r_time_one       <= trm_pkg::RST_TIME_ONE;
            r_time_two       <= trm_pkg::RST_TIME_TWO;
            r_time_three     <= trm_pkg::RST_TIME_THREE;
            r_time_four      <= trm_pkg::RST_TIME_FOUR;
            r_time_abs       <= trm_pkg::RST_TIME_ABS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                trm_pkg::CFG_STEP_DEGREES:   r_step_degrees   <= i_cfg_data[7:0];
                trm_pkg::CFG_ABSOLUTE_LIMIT: r_absolute_limit <= i_cfg_data[9:0];
                trm_pkg::CFG_TIME_ONE:       r_time_one       <= i_cfg_data;
                trm_pkg::CFG_TIME_TWO:       r_time_two       <= i_cfg_data;
                trm_pkg::CFG_TIME_THREE:     r_time_three     <= i_cfg_data;
                trm_pkg::CFG_TIME_FOUR:      r_time_four      <= i_cfg_data;
                trm_pkg::CFG_TIME_ABS:       r_time_abs       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // check state
    logic [CW-1:0]            r_cnt;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_in_overrun;
    logic [trm_pkg::MS_W-1:0] r_start;
    logic                     r_trip;

    // output buffer
    logic             r_out_valid;
    logic             r_skid_valid;
    trm_pkg::t_result r_out;
    trm_pkg::t_result r_skid;

    logic w_accept;
    logic w_take;

    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_take     = r_out_valid && !i_out_stall;

    // restart sequencing
    logic [CW-1:0] w_cnt_req;
    logic [CW-1:0] w_cnt_adv;
    logic [CW-1:0] w_cnt_after;
    logic [CW-1:0] n_cnt;
    logic          w_clear;
    logic          w_shift;

    always_comb begin
        w_cnt_req = (i_restart_history && (RESET_CHECKS > 0)) ? CW'(1) : r_cnt;
        w_cnt_adv = CW'(w_cnt_req + CW'(1));
        if (w_cnt_req == '0) begin
            w_cnt_after = '0;
        end else if ({1'b0, w_cnt_adv} >= (CW + 1)'(RESET_CHECKS)) begin
            w_cnt_after = '0;
        end else begin
            w_cnt_after = w_cnt_adv;
        end
        w_clear = !i_bypass && (w_cnt_req == CW'(1));
        w_shift = !i_bypass && (w_cnt_after == '0);
        n_cnt   = i_bypass ? w_cnt_req : w_cnt_after;
    end

    // history chain, cell 0 takes the new power, the last cell holds the oldest
    logic [PW-1:0] w_tap     [HISTORY_DEPTH];
    logic [PW-1:0] w_cell_in [HISTORY_DEPTH];

    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_cell_in[k] = i_power_pct;
        end else begin : g_body
            assign w_cell_in[k] = w_clear ? '0 : w_tap[k-1];
        end
        trm_hist_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept && w_shift),
            .i_clear (w_accept && w_clear),
            .i_data  (w_cell_in[k]),
            .o_data  (w_tap[k])
        );
    end

    // running sum and average by reciprocal multiply
    logic [SUM_W-1:0]   w_sum_base;
    logic [SUM_W-1:0]   w_oldest;
    logic [SUM_W-1:0]   n_sum;
    logic [PROD_W-1:0]  w_prod;
    logic [PW-1:0]      w_avg;
    logic [RECIP_W-1:0] w_recip;

    assign w_recip    = RECIP_W'(RECIP);
    assign w_sum_base = w_clear ? '0 : r_sum;
    assign w_oldest   = w_clear ? '0 : SUM_W'(w_tap[HISTORY_DEPTH-1]);
    assign n_sum      = w_shift ? SUM_W'(w_sum_base - w_oldest + SUM_W'(i_power_pct))
                                : w_sum_base;
    assign w_prod     = PROD_W'(n_sum) * PROD_W'(w_recip);
    assign w_avg      = w_shift ? w_prod[SHIFT +: PW] : '0;

    // pwm check
    logic w_pwm_fault;

    assign w_pwm_fault = !i_bypass
        && (({1'b0, i_pwm_out} > ({1'b0, i_pwm_period} + 17'd1))
            || (i_pwm_out != i_pwm_readback));

    // grading
    trm_pkg::t_grade_cfg w_grade_cfg;
    trm_pkg::t_level     w_graded;
    trm_pkg::t_level     w_level;
    logic                w_grade_en;

    assign w_grade_cfg.step_degrees   = r_step_degrees;
    assign w_grade_cfg.absolute_limit = r_absolute_limit;

    trm_grade u_grade (
        .i_tip    (i_tip_temp),
        .i_target (i_target_temp),
        .i_cfg    (w_grade_cfg),
        .o_level  (w_graded)
    );

    assign w_grade_en = !i_bypass && (w_avg != '0) && !r_trip
                        && (i_tip_temp > i_target_temp);
    assign w_level    = w_grade_en ? w_graded : trm_pkg::LVL_NONE;

    // overrun timer
    logic [trm_pkg::TIME_W-1:0] w_limit;
    logic [trm_pkg::MS_W-1:0]   w_elapsed;
    logic                       n_in_overrun;
    logic [trm_pkg::MS_W-1:0]   n_start;
    logic                       n_trip;
    trm_pkg::t_level            w_fault;

    always_comb begin
        unique case (w_graded)
            trm_pkg::LVL_ONE:   w_limit = r_time_one;
            trm_pkg::LVL_TWO:   w_limit = r_time_two;
            trm_pkg::LVL_THREE: w_limit = r_time_three;
            trm_pkg::LVL_FOUR:  w_limit = r_time_four;
            default:            w_limit = r_time_abs;
        endcase
    end

    assign w_elapsed = i_now_ms - r_start;

    always_comb begin
        n_in_overrun = r_in_overrun;
        n_start      = r_start;
        n_trip       = r_trip;
        w_fault      = trm_pkg::LVL_NONE;
        if (!i_bypass) begin
            if (w_grade_en) begin
                if (w_level != trm_pkg::LVL_NONE) begin
                    if (!r_in_overrun) begin
                        n_in_overrun = 1'b1;
                        n_start      = i_now_ms;
                    end else if (w_elapsed > trm_pkg::MS_W'(w_limit)) begin
                        n_trip  = 1'b1;
                        w_fault = w_level;
                    end
                end
            end else begin
                n_in_overrun = 1'b0;
                n_start      = i_now_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_sum        <= '0;
            r_in_overrun <= 1'b0;
            r_start      <= '0;
            r_trip       <= 1'b0;
        end else if (w_accept) begin
            r_cnt        <= n_cnt;
            r_sum        <= n_sum;
            r_in_overrun <= n_in_overrun;
            r_start      <= n_start;
            r_trip       <= n_trip;
        end
    end

    trm_pkg::t_result w_result;

    assign w_result.level     = w_level;
    assign w_result.fault     = w_fault;
    assign w_result.tripped   = n_trip;
    assign w_result.pwm_fault = w_pwm_fault;
    assign w_result.avg       = w_avg;

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_result;
            end
        end else if (w_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_overrun_level = r_out.level;
    assign o_fault_code    = r_out.fault;
    assign o_tripped       = r_out.tripped;
    assign o_pwm_fault     = r_out.pwm_fault;
    assign o_average_power = r_out.avg;

    a_fault_trips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.fault != trm_pkg::LVL_NONE)) |-> r_out.tripped)
        else $error("fault code shown without the trip latch");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_trip_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_trip))
        else $error("trip latch cleared outside reset");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt} < (CW + 1)'(RESET_CHECKS)) || (r_cnt == '0))
        else $error("restart count beyond its window");

    a_trip_fault_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_trip) |-> (w_fault == trm_pkg::LVL_NONE))
        else $error("fault reported after the latch was already set");

endmodule
